[hdl/scs_pkg.sv]
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types and constants of the screen cycle slide sequencer: register
// indexes, reset values, action codes and the structs between the modules.
// ----------------------------------------------------------------------------
package scs_pkg;

  // default geometry of the slide and of the screen ring
  localparam int FRAME_WIDTH_DEF  = 160;
  localparam int SLIDE_STEPS_DEF  = 24;
  localparam int SCREEN_COUNT_DEF = 5;

  // fixed widths of the ports
  localparam int TIME_W   = 32;
  localparam int CFG_W    = 16;
  localparam int INDEX_W  = 3;
  localparam int ACTION_W = 3;
  localparam int SCREEN_W = 3;
  localparam int OFFSET_W = 8;

  // register reset values
  localparam logic [CFG_W-1:0] REDRAW_RST = 16'd600;
  localparam logic [CFG_W-1:0] SPLASH_RST = 16'd6000;
  localparam logic [CFG_W-1:0] LOGO_RST   = 16'd4000;
  localparam logic [CFG_W-1:0] SCREEN_RST = 16'd4000;
  localparam logic [CFG_W-1:0] STEP_RST   = 16'd70;

  // register indexes on the config port
  typedef enum logic [INDEX_W-1:0] {
    REG_REDRAW = 3'd0,
    REG_SPLASH = 3'd1,
    REG_LOGO   = 3'd2,
    REG_SCREEN = 3'd3,
    REG_STEP   = 3'd4
  } reg_idx_t;

  // result action codes
  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_REDRAW = 3'd1,
    ACT_BEGIN  = 3'd2,
    ACT_STEP   = 3'd3,
    ACT_FINAL  = 3'd4
  } action_t;

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [CFG_W-1:0] redraw_interval_ms;
    logic [CFG_W-1:0] splash_dwell_ms;
    logic [CFG_W-1:0] logo_dwell_ms;
    logic [CFG_W-1:0] screen_dwell_ms;
    logic [CFG_W-1:0] slide_step_ms;
  } cfg_t;

  // one result beat
  typedef struct packed {
    action_t             action;
    logic [SCREEN_W-1:0] shown_screen;
    logic [SCREEN_W-1:0] incoming_screen;
    logic [OFFSET_W-1:0] slide_offset;
  } result_t;

endpackage

[hdl/scs_cfg_regs.sv]
// ----------------------------------------------------------------------------
// scs_cfg_regs
// Timing register file: five 16-bit intervals written over the config port,
// unknown indexes ignored.
// ----------------------------------------------------------------------------
module scs_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [scs_pkg::INDEX_W-1:0]   wr_index,
  input  logic [scs_pkg::CFG_W-1:0]     wr_data,
  output scs_pkg::cfg_t                 cfg
);
  import scs_pkg::*;

  cfg_t regs;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.redraw_interval_ms <= REDRAW_RST;
      regs.splash_dwell_ms    <= SPLASH_RST;
      regs.logo_dwell_ms      <= LOGO_RST;
      regs.screen_dwell_ms    <= SCREEN_RST;
      regs.slide_step_ms      <= STEP_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_REDRAW: regs.redraw_interval_ms <= wr_data;
        REG_SPLASH: regs.splash_dwell_ms    <= wr_data;
        REG_LOGO:   regs.logo_dwell_ms      <= wr_data;
        REG_SCREEN: regs.screen_dwell_ms    <= wr_data;
        REG_STEP:   regs.slide_step_ms      <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

[hdl/scs_core.sv]
// ----------------------------------------------------------------------------
// scs_core
// Sequencer state and per-beat decision: slide pacing, dwell expiry and the
// redraw throttle, each a 32-bit wrapping subtract and compare.
// ----------------------------------------------------------------------------
module scs_core #(
  parameter int FRAME_WIDTH  = scs_pkg::FRAME_WIDTH_DEF,
  parameter int SLIDE_STEPS  = scs_pkg::SLIDE_STEPS_DEF,
  parameter int SCREEN_COUNT = scs_pkg::SCREEN_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         fire,
  input  logic [scs_pkg::TIME_W-1:0]   now,
  input  scs_pkg::cfg_t                cfg,
  output scs_pkg::result_t             res
);
  import scs_pkg::*;

  localparam int SW      = $clog2(SCREEN_COUNT);
  localparam int STW     = $clog2(SLIDE_STEPS + 1);
  localparam int OW      = $clog2(FRAME_WIDTH + 1);
  localparam int RW      = $clog2(SLIDE_STEPS + 1);
  localparam int OFF_INC = FRAME_WIDTH / SLIDE_STEPS;
  localparam int REM_INC = FRAME_WIDTH % SLIDE_STEPS;

  localparam logic [SW-1:0]  LAST_SCREEN = SW'(SCREEN_COUNT - 1);
  localparam logic [SW-1:0]  FIRST_DATA  = SW'(1);
  localparam logic [STW-1:0] LAST_STEP   = STW'(SLIDE_STEPS);
  localparam logic [RW:0]    STEPS_WIDE  = (RW + 1)'(SLIDE_STEPS);

  // state
  logic [SW-1:0]     screen_index,     screen_index_next;
  logic [TIME_W-1:0] entered_time,     entered_time_next;
  logic [TIME_W-1:0] last_redraw_time, last_redraw_time_next;
  logic              splash_finished,  splash_finished_next;
  logic              sliding,          sliding_next;
  logic [SW-1:0]     target_screen,    target_screen_next;
  logic [STW-1:0]    slide_step,       slide_step_next;
  logic [TIME_W-1:0] last_step_time,   last_step_time_next;
  // running offset step*FRAME_WIDTH/SLIDE_STEPS as quotient and remainder
  logic [OW-1:0]     offset_acc,       offset_acc_next;
  logic [RW-1:0]     offset_rem,       offset_rem_next;

  logic [TIME_W-1:0] since_step, since_enter, since_redraw;
  logic [CFG_W-1:0]  dwell;
  logic [SW-1:0]     ring_next;
  logic [RW:0]       rem_sum;
  logic              step_due, dwell_done, redraw_due, last_one;
  logic [SW+SCREEN_W-1:0] shown_ext, target_ext, next_ext;
  logic [OW+OFFSET_W-1:0] offset_ext;

  // elapsed times, modulo 2^32
  assign since_step   = now - last_step_time;
  assign since_enter  = now - entered_time;
  assign since_redraw = now - last_redraw_time;

  always_comb begin
    if (screen_index == '0) begin
      dwell = splash_finished ? cfg.logo_dwell_ms : cfg.splash_dwell_ms;
    end else begin
      dwell = cfg.screen_dwell_ms;
    end
  end

  assign step_due   = since_step   >= TIME_W'(cfg.slide_step_ms);
  assign dwell_done = since_enter  >= TIME_W'(dwell);
  assign redraw_due = since_redraw >= TIME_W'(cfg.redraw_interval_ms);
  assign ring_next  = (screen_index == LAST_SCREEN) ? '0 : screen_index + SW'(1);
  assign last_one   = slide_step == LAST_STEP;
  assign rem_sum    = {1'b0, offset_rem} + (RW + 1)'(REM_INC);

  // fit screens and offset into the port widths
  assign shown_ext  = {{SCREEN_W{1'b0}}, screen_index};
  assign target_ext = {{SCREEN_W{1'b0}}, target_screen};
  assign next_ext   = {{SCREEN_W{1'b0}}, ring_next};
  assign offset_ext = {{OFFSET_W{1'b0}}, offset_acc};

  // next state and result
  always_comb begin
    screen_index_next     = screen_index;
    entered_time_next     = entered_time;
    last_redraw_time_next = last_redraw_time;
    splash_finished_next  = splash_finished;
    sliding_next          = sliding;
    target_screen_next    = target_screen;
    slide_step_next       = slide_step;
    last_step_time_next   = last_step_time;
    offset_acc_next       = offset_acc;
    offset_rem_next       = offset_rem;

    res.action          = ACT_NONE;
    res.shown_screen    = shown_ext[SCREEN_W-1:0];
    res.incoming_screen = '0;
    res.slide_offset    = '0;

    if (sliding) begin
      res.incoming_screen = target_ext[SCREEN_W-1:0];
      if (step_due) begin
        res.action          = last_one ? ACT_FINAL : ACT_STEP;
        res.slide_offset    = offset_ext[OFFSET_W-1:0];
        last_step_time_next = now;
        slide_step_next     = slide_step + STW'(1);
        // advance the offset by FRAME_WIDTH/SLIDE_STEPS with carry
        if (rem_sum >= STEPS_WIDE) begin
          offset_rem_next = RW'(rem_sum - STEPS_WIDE);
          offset_acc_next = offset_acc + OW'(OFF_INC + 1);
        end else begin
          offset_rem_next = RW'(rem_sum);
          offset_acc_next = offset_acc + OW'(OFF_INC);
        end
        if (last_one) begin
          sliding_next      = 1'b0;
          screen_index_next = target_screen;
          entered_time_next = now;
        end
      end
    end else if (dwell_done) begin
      res.action          = ACT_BEGIN;
      res.incoming_screen = next_ext[SCREEN_W-1:0];
      if (screen_index == '0) begin
        splash_finished_next = 1'b1;
      end
      target_screen_next  = ring_next;
      sliding_next        = 1'b1;
      slide_step_next     = '0;
      offset_acc_next     = '0;
      offset_rem_next     = '0;
      last_step_time_next = now;
    end else if (redraw_due) begin
      res.action            = ACT_REDRAW;
      last_redraw_time_next = now;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_index     <= '0;
      entered_time     <= '0;
      last_redraw_time <= '0;
      splash_finished  <= 1'b0;
      sliding          <= 1'b0;
      target_screen    <= FIRST_DATA;
      slide_step       <= '0;
      last_step_time   <= '0;
      offset_acc       <= '0;
      offset_rem       <= '0;
    end else if (fire) begin
      screen_index     <= screen_index_next;
      entered_time     <= entered_time_next;
      last_redraw_time <= last_redraw_time_next;
      splash_finished  <= splash_finished_next;
      sliding          <= sliding_next;
      target_screen    <= target_screen_next;
      slide_step       <= slide_step_next;
      last_step_time   <= last_step_time_next;
      offset_acc       <= offset_acc_next;
      offset_rem       <= offset_rem_next;
    end
  end

`ifndef SYNTH
  // step counter never runs past the final step while sliding
  assert property (@(posedge clk) disable iff (rst)
    sliding |-> slide_step <= LAST_STEP)
    else $error("slide step beyond final step");

  // screen numbers stay inside the ring
  assert property (@(posedge clk) disable iff (rst)
    screen_index <= LAST_SCREEN && target_screen <= LAST_SCREEN)
    else $error("screen index outside ring");

  // final step lands on the target screen and ends the slide
  assert property (@(posedge clk) disable iff (rst)
    fire && res.action == ACT_FINAL |=>
      !sliding && screen_index == $past(target_screen))
    else $error("final step did not land on target");

  // begin slide restarts the step counter and offset
  assert property (@(posedge clk) disable iff (rst)
    fire && res.action == ACT_BEGIN |=>
      sliding && slide_step == '0 && offset_acc == '0)
    else $error("slide did not restart");
`endif

endmodule

[hdl/screen_cycle_slide_sequencer.sv]
// ----------------------------------------------------------------------------
// screen_cycle_slide_sequencer
// Screen ring sequencer: per timestamp beat, decides redraw, slide start or
// slide step and the slide offset, with an input and a result register.
// ----------------------------------------------------------------------------
// a timestamp passes the input register and then the result register before its result beat is valid
// throughput: one timestamp per cycle while out_stall is low, set by the single state update stage
// a stalled result holds; the input side keeps taking beats while the
// input register has room, so stall reaches back only when both are full
// reset: synchronous, returns config registers, valid flags and sequencer state to
// power-on values at once, no clearing pass
module screen_cycle_slide_sequencer #(
  parameter int FRAME_WIDTH  = scs_pkg::FRAME_WIDTH_DEF,
  parameter int SLIDE_STEPS  = scs_pkg::SLIDE_STEPS_DEF,
  parameter int SCREEN_COUNT = scs_pkg::SCREEN_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // timestamp channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [scs_pkg::TIME_W-1:0]     now_ms,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [scs_pkg::ACTION_W-1:0]   action,
  output logic [scs_pkg::SCREEN_W-1:0]   shown_screen,
  output logic [scs_pkg::SCREEN_W-1:0]   incoming_screen,
  output logic [scs_pkg::OFFSET_W-1:0]   slide_offset,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scs_pkg::INDEX_W-1:0]    cfg_index,
  input  logic [scs_pkg::CFG_W-1:0]      cfg_data
);
  import scs_pkg::*;

  cfg_t              cfg;
  result_t           res;
  result_t           res_r;
  logic              hold_valid;
  logic [TIME_W-1:0] hold_now;
  logic              advance;
  logic              in_take;

  assign cfg_ready = 1'b1;

  scs_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // held beat moves on when the result register is free or draining
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_take) begin
      hold_valid <= 1'b1;
    end else if (advance) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_now <= now_ms;
    end
  end

  scs_core #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .SLIDE_STEPS  (SLIDE_STEPS),
    .SCREEN_COUNT (SCREEN_COUNT)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .now  (hold_now),
    .cfg  (cfg),
    .res  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign action          = res_r.action;
  assign shown_screen    = res_r.shown_screen;
  assign incoming_screen = res_r.incoming_screen;
  assign slide_offset    = res_r.slide_offset;

endmodule
